[rtl/keyed_log2_histogram_defines.svh]
// Assertion macros shared by the histogram RTL.
// Depends on a clk and an active-low rst_n in the module that uses them.
`ifndef KEYED_LOG2_HISTOGRAM_DEFINES_SVH
`define KEYED_LOG2_HISTOGRAM_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define KLH_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: assertion failed");

// Check that a condition implies another in the same cycle.
`define KLH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Check that a condition implies another in the next cycle.
`define KLH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/klh_pkg.sv]
// Types, codes and helpers for the keyed log2 histogram.
// No dependencies; used by all histogram modules.
`default_nettype none

package klh_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_MERGE  = 2'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BIDX_W  = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_MERGE  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  // One classified beat passed from front to back.
  typedef struct packed {
    op_t               op;
    logic              zero;
    logic [KEY_W-1:0]  key;
    logic [BIDX_W-1:0] bin;
    logic [CNT_W-1:0]  addend;
  } item_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // Position of the highest set bit; zero for zero.
  function automatic logic [4:0] floor_log2(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/klh_front.sv]
// Front end: decodes the action, picks and clamps the bin, flags zero samples.
// Depends on klh_pkg.
`default_nettype none

module klh_front #(
  parameter int unsigned BIN_COUNT = 32
) (
  input  wire logic [1:0]  in_action,
  input  wire logic [63:0] in_key,
  input  wire logic [31:0] in_value,
  input  wire logic [4:0]  in_bin,
  input  wire logic [31:0] in_merge_count,
  output klh_pkg::item_t   item
);

  logic [klh_pkg::BIDX_W-1:0] raw_bin;

  // Decode action; unused code reads.
  always_comb begin
    item.key    = in_key;
    item.zero   = 1'b0;
    item.addend = in_merge_count;
    raw_bin     = {1'b0, in_bin};
    unique case (in_action)
      klh_pkg::ACT_RECORD: begin
        item.op     = klh_pkg::OP_RECORD;
        item.zero   = (in_value == 32'd0);
        item.addend = 32'd1;
        raw_bin     = {1'b0, klh_pkg::floor_log2(in_value)};
      end
      klh_pkg::ACT_MERGE: begin
        item.op = klh_pkg::OP_MERGE;
      end
      default: begin
        item.op = klh_pkg::OP_READ;
      end
    endcase
    // Clamp bin to the last one.
    if ({1'b0, raw_bin} >= 7'(BIN_COUNT)) begin
      item.bin = klh_pkg::BIDX_W'(BIN_COUNT - 1);
    end else begin
      item.bin = raw_bin;
    end
  end

endmodule

`default_nettype wire

[rtl/klh_queue.sv]
// Two-entry queue between front and back ends.
// Depends on klh_pkg.
`default_nettype none

module klh_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire klh_pkg::item_t push_item,
  input  wire logic           pop,
  output klh_pkg::item_t      head,
  output klh_pkg::q_stat_t    stat
);

  klh_pkg::item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Advance pointers and count.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed beats.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.valid = (cnt_r != 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

endmodule

`default_nettype wire

[rtl/klh_back.sv]
// Back end: key scan, slot allocation, bin clear and count update.
// Depends on klh_pkg and keyed_log2_histogram_defines.svh.
`include "keyed_log2_histogram_defines.svh"
`default_nettype none

module klh_back #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned BIN_COUNT     = 32,
  parameter int unsigned KEY_BITS      = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire klh_pkg::item_t   head,
  input  wire klh_pkg::q_stat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_status,
  output logic [5:0]            out_slot,
  output logic [4:0]            out_bin_used,
  output logic [31:0]           out_bin_count
);

  localparam int unsigned SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned BIN_W  = $clog2(BIN_COUNT);
  localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES * BIN_COUNT);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_RD  = 6'b000010,
    S_SCAN_CMP = 6'b000100,
    S_CLEAR    = 6'b001000,
    S_CNT_RD   = 6'b010000,
    S_CNT_UPD  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  klh_pkg::item_t        cur_r, cur_nxt;
  logic [SLOT_W:0]       fill_r, fill_nxt;
  logic [SLOT_W:0]       idx_r, idx_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [BIN_W-1:0]      clr_r, clr_nxt;

  logic [KEY_BITS-1:0]   key_mem [TABLE_ENTRIES];
  logic [KEY_BITS-1:0]   key_rd_r;
  logic                  key_we;
  logic [31:0]           cnt_mem [TABLE_ENTRIES * BIN_COUNT];
  logic [31:0]           cnt_rd_r;
  logic                  cnt_we;
  logic [31:0]           cnt_wdata;
  logic [BIN_W-1:0]      bin_sel;
  logic [ADDR_W-1:0]     cnt_addr;
  logic [32:0]           sum;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [5:0]            oslot_r, oslot_nxt;
  logic [4:0]            obin_r, obin_nxt;
  logic [31:0]           ocnt_r, ocnt_nxt;
  logic                  out_free;
  logic                  out_load;
  logic [SLOT_W+5:0]     slot_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign slot_ext = {6'd0, slot_r};
  assign bin_sel  = (state_r == S_CLEAR) ? clr_r : cur_r.bin[BIN_W-1:0];
  assign cnt_addr = ADDR_W'(slot_r * BIN_COUNT) + ADDR_W'(bin_sel);
  assign sum      = {1'b0, cnt_rd_r} + {1'b0, cur_r.addend};

  // Sequence one item at a time.
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    clr_nxt       = clr_r;
    pop           = 1'b0;
    key_we        = 1'b0;
    cnt_we        = 1'b0;
    cnt_wdata     = 32'd0;
    out_load      = 1'b0;
    status_nxt    = status_r;
    oslot_nxt     = oslot_r;
    obin_nxt      = obin_r;
    ocnt_nxt      = ocnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (qstat.valid && out_free) begin
          pop     = 1'b1;
          cur_nxt = head;
          idx_nxt = '0;
          if (head.zero) begin
            out_load   = 1'b1;
            status_nxt = klh_pkg::ST_ZERO;
            oslot_nxt  = 6'd0;
            obin_nxt   = 5'd0;
            ocnt_nxt   = 32'd0;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_r == fill_r) begin
          // Key absent: refuse, report or allocate.
          if (cur_r.op == klh_pkg::OP_READ || fill_r == (SLOT_W+1)'(TABLE_ENTRIES)) begin
            out_load   = 1'b1;
            status_nxt = (cur_r.op == klh_pkg::OP_READ) ? klh_pkg::ST_MISSING
                                                         : klh_pkg::ST_FULL;
            oslot_nxt  = 6'd0;
            obin_nxt   = cur_r.bin[4:0];
            ocnt_nxt   = 32'd0;
            state_nxt  = S_IDLE;
          end else begin
            key_we    = 1'b1;
            slot_nxt  = fill_r[SLOT_W-1:0];
            fill_nxt  = fill_r + 1'b1;
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (key_rd_r == cur_r.key[KEY_BITS-1:0]) begin
          slot_nxt  = idx_r[SLOT_W-1:0];
          state_nxt = S_CNT_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_CLEAR: begin
        // Zero the new slot's bins.
        cnt_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BIN_W'(BIN_COUNT - 1)) state_nxt = S_CNT_RD;
      end
      S_CNT_RD: begin
        state_nxt = S_CNT_UPD;
      end
      S_CNT_UPD: begin
        if (cur_r.op == klh_pkg::OP_READ) begin
          cnt_wdata = cnt_rd_r;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = sum[32] ? klh_pkg::CNT_MAX : sum[31:0];
        end
        out_load   = 1'b1;
        status_nxt = klh_pkg::ST_OK;
        oslot_nxt  = slot_ext[5:0];
        obin_nxt   = cur_r.bin[4:0];
        ocnt_nxt   = cnt_wdata;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold working payload.
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    clr_r    <= clr_nxt;
    status_r <= status_nxt;
    oslot_r  <= oslot_nxt;
    obin_r   <= obin_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  // Key memory: write on allocation, registered read for the scan.
  always_ff @(posedge clk) begin
    if (key_we) key_mem[fill_r[SLOT_W-1:0]] <= cur_r.key[KEY_BITS-1:0];
    key_rd_r <= key_mem[idx_r[SLOT_W-1:0]];
  end

  // Count memory: single address, registered read.
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
    cnt_rd_r <= cnt_mem[cnt_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_slot      = oslot_r;
  assign out_bin_used  = obin_r;
  assign out_bin_count = ocnt_r;

  `KLH_ASSERT(a_fill_bound, fill_r <= (SLOT_W+1)'(TABLE_ENTRIES))
  `KLH_ASSERT_IMP(a_load_free, out_load, out_free)
  `KLH_ASSERT_NEXT(a_alloc_step, key_we, fill_r == $past(fill_r) + 1'b1)
  `KLH_ASSERT_IMP(a_full_only, out_load && status_nxt == klh_pkg::ST_FULL, fill_r == (SLOT_W+1)'(TABLE_ENTRIES))

endmodule

`default_nettype wire

[rtl/keyed_log2_histogram.sv]
// Keyed log2 histogram: one result beat per input beat, one item at a time.
// Zero samples are answered from idle; other items scan stored keys, reading then
// comparing each entry. A found key gets a count read and update; a missing key or
// full table is answered at scan end; a new key is allocated and its bins cleared
// first. An item holds the back end till done; later beats wait in the two-entry queue.
// Reset clears control state and the fill count; no clearing pass is run.
`default_nettype none

module keyed_log2_histogram #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned BIN_COUNT     = 32,
  parameter int unsigned KEY_BITS      = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [63:0] in_key,
  input  wire logic [31:0] in_value,
  input  wire logic [4:0]  in_bin,
  input  wire logic [31:0] in_merge_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [5:0]       out_slot,
  output logic [4:0]       out_bin_used,
  output logic [31:0]      out_bin_count
);

  klh_pkg::item_t   front_item;
  klh_pkg::item_t   head;
  klh_pkg::q_stat_t qstat;
  logic             push;
  logic             pop;

  // Accept a beat whenever the queue has room.
  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  klh_front #(.BIN_COUNT(BIN_COUNT)) u_front (
    .in_action      (in_action),
    .in_key         (in_key),
    .in_value       (in_value),
    .in_bin         (in_bin),
    .in_merge_count (in_merge_count),
    .item           (front_item)
  );

  klh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  klh_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .BIN_COUNT     (BIN_COUNT),
    .KEY_BITS      (KEY_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_bin_used  (out_bin_used),
    .out_bin_count (out_bin_count)
  );

endmodule

`default_nettype wire

[tb/keyed_log2_histogram_test.sv]
// Self-checking bench for keyed_log2_histogram: a local predictor keeps its own
// key table and bin counts and checks each result beat. Depends on klh_pkg.
`default_nettype none

module keyed_log2_histogram_test;

  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned BINS      = 32;
  localparam int unsigned KEY_POOL  = 80;
  localparam int unsigned STALL_MAX = 20000;
  localparam logic [1:0]  ACT_READ  = 2'd2;
  localparam logic [1:0]  ACT_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [4:0]  bin_used;
    logic [31:0] bin_count;
  } hist_result_t;

  // Shadow histogram table and the queue of expected results.
  class hist_scoreboard;
    logic [63:0]  keys [ENTRIES];
    bit           used [ENTRIES];
    logic [31:0]  counts [ENTRIES*BINS];
    int unsigned  fill;
    hist_result_t pending [$];
    int unsigned  errors;

    function new();
      fill = 0;
      errors = 0;
      foreach (used[i]) used[i] = 0;
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function int lookup(logic [63:0] k);
      for (int i = 0; i < ENTRIES; i++) begin
        if (used[i] && keys[i] == k) return i;
      end
      return -1;
    endfunction

    function int lookup_or_claim(logic [63:0] k);
      int s;
      s = lookup(k);
      if (s >= 0) return s;
      if (fill >= ENTRIES) return -1;
      s = fill;
      keys[s] = k;
      used[s] = 1;
      for (int b = 0; b < BINS; b++) counts[s*BINS+b] = '0;
      fill++;
      return s;
    endfunction

    // Apply one accepted input beat and queue its result.
    function void note_input(logic [1:0] act, logic [63:0] k, logic [31:0] val,
                             logic [4:0] bin, logic [31:0] addend);
      hist_result_t r;
      int s;
      int unsigned lg;
      logic [32:0] sum;
      r = '{klh_pkg::ST_OK, 6'd0, 5'd0, 32'd0};
      if (act == klh_pkg::ACT_RECORD && val == 0) begin
        r.status = klh_pkg::ST_ZERO;
      end else begin
        if (act == klh_pkg::ACT_RECORD) begin
          lg = 0;
          for (int i = 1; i < 32; i++) if (val[i]) lg = i;
          addend = 32'd1;
        end else begin
          lg = bin;
        end
        if (lg >= BINS) lg = BINS - 1;
        r.bin_used = 5'(lg);
        s = (act == klh_pkg::ACT_RECORD || act == klh_pkg::ACT_MERGE) ?
            lookup_or_claim(k) : lookup(k);
        if (s < 0) begin
          r.status = (act == ACT_READ || act == ACT_SPARE) ? klh_pkg::ST_MISSING
                                                           : klh_pkg::ST_FULL;
        end else begin
          if (act == klh_pkg::ACT_RECORD || act == klh_pkg::ACT_MERGE) begin
            sum = {1'b0, counts[s*BINS+lg]} + {1'b0, addend};
            counts[s*BINS+lg] = sum[32] ? klh_pkg::CNT_MAX : sum[31:0];
          end
          r.slot = 6'(s);
          r.bin_count = counts[s*BINS+lg];
        end
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
    endtask

    // Compare one accepted result beat with the oldest expectation.
    task check_result(hist_result_t got);
      hist_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(got.status), 32'd0);
      end else begin
        want = pending.pop_front();
        if (got.status != want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.slot != want.slot)
          report_mismatch("slot", 32'(got.slot), 32'(want.slot));
        if (got.bin_used != want.bin_used)
          report_mismatch("bin_used", 32'(got.bin_used), 32'(want.bin_used));
        if (got.bin_count != want.bin_count)
          report_mismatch("bin_count", got.bin_count, want.bin_count);
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [63:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic [4:0]  in_bin = '0;
  logic [31:0] in_merge_count = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_status;
  logic [5:0]  out_slot;
  logic [4:0]  out_bin_used;
  logic [31:0] out_bin_count;

  hist_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [63:0] key_pool [KEY_POOL];

  keyed_log2_histogram DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_key, .in_value, .in_bin,
    .in_merge_count, .out_valid, .out_stall, .out_status, .out_slot,
    .out_bin_used, .out_bin_count
  );

  always #5 clk = ~clk;

  // Random backpressure on the result side.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Check result beats.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_status, out_slot, out_bin_used, out_bin_count});
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one beat, with random idle cycles ahead of it.
  task send_beat(logic [1:0] act, logic [63:0] k, logic [31:0] val,
                 logic [4:0] bin, logic [31:0] addend);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_action = act;
    in_key = k;
    in_value = val;
    in_bin = bin;
    in_merge_count = addend;
    do @(posedge clk); while (in_stall);
    sb.note_input(act, k, val, bin, addend);
  endtask

  task drain_results;
    @(negedge clk);
    in_valid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task random_beats(int unsigned n);
    logic [1:0]  act;
    logic [63:0] k;
    logic [31:0] val;
    logic [31:0] addend;
    for (int unsigned i = 0; i < n; i++) begin
      act = 2'($urandom_range(0, 99) < 45 ? klh_pkg::ACT_RECORD :
               $urandom_range(0, 99) < 55 ? klh_pkg::ACT_MERGE : $urandom_range(2, 3));
      k = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, KEY_POOL-1)]
                                      : {$urandom, $urandom};
      val = ($urandom_range(0, 19) == 0) ? 32'd0 : ($urandom >> $urandom_range(0, 31));
      addend = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 100));
      send_beat(act, k, val, 5'($urandom), addend);
      if (i == n / 2 && n > 100) drain_results();
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: extremes, every action, zero sample, missing key, saturation.
    send_beat(klh_pkg::ACT_RECORD, 64'd0, 32'd0, 5'd0, 32'd0);
    send_beat(ACT_READ, 64'd0, 32'd0, 5'd0, 32'd0);
    send_beat(klh_pkg::ACT_RECORD, 64'd0, 32'd1, 5'd31, 32'd0);
    send_beat(klh_pkg::ACT_RECORD, 64'd0, 32'hFFFF_FFFF, 5'd0, 32'd0);
    send_beat(klh_pkg::ACT_RECORD, '1, 32'h8000_0000, 5'd0, 32'hFFFF_FFFF);
    send_beat(klh_pkg::ACT_MERGE, '1, 32'd0, 5'd31, 32'hFFFF_FFFF);
    send_beat(klh_pkg::ACT_RECORD, '1, 32'hC000_0000, 5'd0, 32'd0);
    send_beat(klh_pkg::ACT_MERGE, '1, 32'd0, 5'd31, 32'd5);
    send_beat(klh_pkg::ACT_MERGE, 64'd0, 32'd0, 5'd0, 32'd0);
    send_beat(klh_pkg::ACT_MERGE, 64'd0, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
    send_beat(klh_pkg::ACT_RECORD, 64'd0, 32'd1, 5'd0, 32'd0);
    send_beat(ACT_READ, '1, 32'd0, 5'd31, 32'd0);
    send_beat(ACT_SPARE, 64'd0, 32'd0, 5'd0, 32'd0);
    send_beat(ACT_READ, 64'h5555_AAAA_5555_AAAA, 32'd0, 5'd7, 32'd0);
    send_beat(ACT_SPARE, 64'h1234_5678_9ABC_DEF0, 32'd0, 5'd3, 32'd0);
    send_beat(klh_pkg::ACT_MERGE, 64'h8000_0000_0000_0001, 32'd0, 5'd16, 32'd1);
    send_beat(ACT_READ, 64'h8000_0000_0000_0001, 32'd0, 5'd16, 32'd0);
    drain_results();

    // Random: sender idles little, receiver much; then swapped; then none.
    send_idle_pct = 10;
    recv_idle_pct = 87;
    random_beats(200);
    send_idle_pct = 87;
    recv_idle_pct = 10;
    random_beats(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_beats(200);

    drain_results();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
